>>> rtl/core/lcfs_pkg.sv
// lcfs_pkg: shared widths, codes and controller/datapath signal groups
// for the led channel fade sequencer; no dependencies
`timescale 1ns / 1ps

package lcfs_pkg;

    localparam int DUTY_W  = 15;
    localparam int STEP_W  = 16;
    localparam int TICK_W  = 7;
    localparam int MODE_W  = 3;
    localparam int GC_W    = 4;
    localparam int OP_W    = 2;
    localparam int GRP_W   = 3;
    localparam int CHN_W   = 3;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 7;
    localparam int NUM_OUT = 5;
    localparam int CH_COOL = 3;
    localparam int CH_WARM = 4;
    localparam int DIV_STEPS = DUTY_W;
    localparam int DCNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_START = 2'd2;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd3;

    localparam logic [MODE_W-1:0] MODE_IMMEDIATE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STATIC    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STEP      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SHADE     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_BREATHE   = 3'd4;

    localparam logic [CFG_IW-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IW-1:0] REG_RAMP_UP   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_HOLD      = 3'd2;
    localparam logic [CFG_IW-1:0] REG_RAMP_DOWN = 3'd3;
    localparam logic [CFG_IW-1:0] REG_GROUPS    = 3'd4;
    localparam logic [CFG_IW-1:0] REG_SNAP      = 3'd5;

    typedef struct packed {
        logic tbl_wr;
        logic rd_req;
        logic div_start;
        logic toward_zero;
        logic step_wr;
        logic warm_chk;
        logic snap_wr;
        logic up_wr;
        logic down_wr;
        logic last;
        logic zero_all;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic warm_zero;
    } t_dp_stat;

endpackage

>>> rtl/core/led_channel_fade_sequencer_core.sv
// led_channel_fade_sequencer_core: top level with configuration registers
// depends on lcfs_pkg, lcfs_ctrl, lcfs_dp
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. Load, start and stop
// items keep busy low, as does a tick while idle. A hold tick that does not
// end the hold returns to idle without a result, and a stop tick zeroes all
// duties before its result. A ramp-up tick reads and writes each channel in
// turn and a ramp-down tick writes each channel in turn. A tick that also
// computes steps (first ramp tick of a group, or the end of a hold) first runs
// each channel through the shared bit-serial step divider, then a warm-zero
// snap check when enabled. A result appears on o_valid for exactly one cycle
// with all five duties, in the first cycle after busy falls; a new item can be
// taken in that same cycle. The receiver cannot stall and results cannot be
// held off.

module led_channel_fade_sequencer_core
    import lcfs_pkg::*;
#(
    parameter int MAX_GROUPS = 8,
    parameter int CHANNELS   = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [GRP_W-1:0]  i_group,
    input  logic [CHN_W-1:0]  i_channel,
    input  logic [DUTY_W-1:0] i_value,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    output logic              o_valid,
    output logic [DUTY_W-1:0] o_duty_red,
    output logic [DUTY_W-1:0] o_duty_green,
    output logic [DUTY_W-1:0] o_duty_blue,
    output logic [DUTY_W-1:0] o_duty_cool,
    output logic [DUTY_W-1:0] o_duty_warm
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int GW = $clog2(MAX_GROUPS + 1);

    logic [MODE_W-1:0] r_mode;
    logic [TICK_W-1:0] r_up;
    logic [TICK_W-1:0] r_hold;
    logic [TICK_W-1:0] r_down;
    logic [GC_W-1:0]   r_gc;
    logic              r_snap;

    logic [TICK_W-1:0] w_up_n;
    logic [TICK_W-1:0] w_hold_n;
    logic [TICK_W-1:0] w_down_n;
    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic [CW-1:0]     w_ch;
    logic [GW-1:0]     w_gi;
    logic [DUTY_W-1:0] w_duty [NUM_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IMMEDIATE;
            r_up   <= TICK_W'(1);
            r_hold <= TICK_W'(1);
            r_down <= TICK_W'(1);
            r_gc   <= '0;
            r_snap <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:      r_mode <= i_cfg_wdata[MODE_W-1:0];
                REG_RAMP_UP:   r_up   <= i_cfg_wdata[TICK_W-1:0];
                REG_HOLD:      r_hold <= i_cfg_wdata[TICK_W-1:0];
                REG_RAMP_DOWN: r_down <= i_cfg_wdata[TICK_W-1:0];
                REG_GROUPS:    r_gc   <= i_cfg_wdata[GC_W-1:0];
                REG_SNAP:      r_snap <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // a zero interval counts as one tick
    assign w_up_n   = (r_up == '0) ? TICK_W'(1) : r_up;
    assign w_hold_n = (r_hold == '0) ? TICK_W'(1) : r_hold;
    assign w_down_n = (r_down == '0) ? TICK_W'(1) : r_down;

    lcfs_ctrl #(
        .MAX_GROUPS (MAX_GROUPS),
        .CHANNELS   (CHANNELS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_operation   (i_operation),
        .i_mode        (r_mode),
        .i_up_n        (w_up_n),
        .i_hold_n      (w_hold_n),
        .i_down_n      (w_down_n),
        .i_group_count (r_gc),
        .i_snap        (r_snap),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd),
        .o_ch          (w_ch),
        .o_gi          (w_gi)
    );

    lcfs_dp #(
        .MAX_GROUPS (MAX_GROUPS),
        .CHANNELS   (CHANNELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_ch           (w_ch),
        .i_gi           (w_gi),
        .i_load_group   (i_group),
        .i_load_channel (i_channel),
        .i_load_value   (i_value),
        .i_divisor      (w_up_n),
        .o_stat         (w_stat),
        .o_valid        (o_valid),
        .o_duty         (w_duty)
    );

    assign o_duty_red   = w_duty[0];
    assign o_duty_green = w_duty[1];
    assign o_duty_blue  = w_duty[2];
    assign o_duty_cool  = w_duty[3];
    assign o_duty_warm  = w_duty[4];

endmodule

>>> rtl/core/lcfs_ctrl.sv
// lcfs_ctrl: sequencer phase and per-item control state machine
// depends on lcfs_pkg
`timescale 1ns / 1ps

module lcfs_ctrl
    import lcfs_pkg::*;
#(
    parameter int MAX_GROUPS = 8,
    parameter int CHANNELS   = 5,
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int GW = $clog2(MAX_GROUPS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [TICK_W-1:0] i_up_n,
    input  logic [TICK_W-1:0] i_hold_n,
    input  logic [TICK_W-1:0] i_down_n,
    input  logic [GC_W-1:0]   i_group_count,
    input  logic              i_snap,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd,
    output logic [CW-1:0]     o_ch,
    output logic [GW-1:0]     o_gi
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_WAIT  = 3'd2;
    localparam logic [2:0] PH_UP    = 3'd3;
    localparam logic [2:0] PH_HOLD  = 3'd4;
    localparam logic [2:0] PH_DOWN  = 3'd5;
    localparam logic [2:0] PH_STOP  = 3'd6;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_WAIT   = 5'd1;
    localparam logic [4:0] S_ST_RD  = 5'd2;
    localparam logic [4:0] S_ST_DV  = 5'd3;
    localparam logic [4:0] S_ST_IT  = 5'd4;
    localparam logic [4:0] S_SN_RD  = 5'd5;
    localparam logic [4:0] S_SN_CK  = 5'd6;
    localparam logic [4:0] S_SN_RD2 = 5'd7;
    localparam logic [4:0] S_SN_WR  = 5'd8;
    localparam logic [4:0] S_UP_INC = 5'd9;
    localparam logic [4:0] S_UP_RD  = 5'd10;
    localparam logic [4:0] S_UP_WR  = 5'd11;
    localparam logic [4:0] S_UP_END = 5'd12;
    localparam logic [4:0] S_HOLD   = 5'd13;
    localparam logic [4:0] S_DN_INC = 5'd14;
    localparam logic [4:0] S_DN_WR  = 5'd15;
    localparam logic [4:0] S_DN_END = 5'd16;
    localparam logic [4:0] S_ZERO   = 5'd17;
    localparam logic [4:0] S_EMIT   = 5'd18;

    logic [4:0]        r_state, n_state;
    logic [2:0]        r_phase, n_phase;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [GW-1:0]     r_gi, n_gi;
    logic [CW-1:0]     r_ch, n_ch;
    logic              r_last, n_last;
    logic              r_tz, n_tz;

    logic              w_accept;
    logic [GW-1:0]     w_gc;
    logic              w_snap_en;
    logic              w_last_ch;
    logic [TICK_W-1:0] w_tick_inc;
    logic [4:0]        w_after_steps;
    t_dp_cmd           w_cmd;

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign o_busy     = (r_state != S_IDLE);
    assign w_gc       = (int'(i_group_count) > MAX_GROUPS) ? GW'(MAX_GROUPS)
                                                           : GW'(i_group_count);
    assign w_snap_en  = i_snap && (CHANNELS > CH_WARM);
    assign w_last_ch  = (r_ch == CW'(CHANNELS - 1));
    assign w_tick_inc = r_tick + 1'b1;
    assign w_after_steps = r_tz ? S_DN_INC : S_UP_INC;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_tick  = r_tick;
        n_gi    = r_gi;
        n_ch    = r_ch;
        n_last  = r_last;
        n_tz    = r_tz;
        w_cmd   = '0;
        w_cmd.tbl_wr = w_accept && (i_operation == OP_LOAD);
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_operation)
                        OP_START: n_phase = (i_group_count == '0) ? PH_STOP : PH_START;
                        OP_STOP:  n_phase = PH_STOP;
                        OP_TICK: begin
                            unique case (r_phase)
                                PH_STOP:  n_state = S_ZERO;
                                PH_START: begin
                                    n_gi    = '0;
                                    n_tick  = '0;
                                    n_phase = PH_WAIT;
                                    n_state = S_WAIT;
                                end
                                PH_WAIT:  n_state = S_WAIT;
                                PH_UP:    n_state = S_UP_INC;
                                PH_HOLD:  n_state = S_HOLD;
                                PH_DOWN:  n_state = S_DN_INC;
                                default:  n_state = S_IDLE;
                            endcase
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_WAIT: begin
                n_tick  = '0;
                n_phase = PH_UP;
                if (r_gi >= w_gc) begin
                    n_gi = '0;
                end
                n_ch    = '0;
                n_tz    = 1'b0;
                n_state = S_ST_RD;
            end
            S_ST_RD: begin
                w_cmd.rd_req = 1'b1;
                n_state      = S_ST_DV;
            end
            S_ST_DV: begin
                w_cmd.div_start   = 1'b1;
                w_cmd.toward_zero = r_tz;
                n_state           = S_ST_IT;
            end
            S_ST_IT: begin
                if (i_stat.div_done) begin
                    w_cmd.step_wr = 1'b1;
                    if (w_last_ch) begin
                        if (w_snap_en) begin
                            n_ch    = CW'(CH_WARM);
                            n_state = S_SN_RD;
                        end else begin
                            n_state = w_after_steps;
                        end
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = S_ST_RD;
                    end
                end
            end
            S_SN_RD: begin
                w_cmd.rd_req = 1'b1;
                n_state      = S_SN_CK;
            end
            S_SN_CK: begin
                w_cmd.warm_chk = 1'b1;
                n_ch           = CW'(CH_COOL);
                n_state        = S_SN_RD2;
            end
            S_SN_RD2: begin
                w_cmd.rd_req = 1'b1;
                n_state      = S_SN_WR;
            end
            S_SN_WR: begin
                w_cmd.snap_wr = i_stat.warm_zero;
                n_state       = w_after_steps;
            end
            S_UP_INC: begin
                n_tick  = w_tick_inc;
                n_last  = (w_tick_inc >= i_up_n);
                n_ch    = '0;
                n_state = S_UP_RD;
            end
            S_UP_RD: begin
                w_cmd.rd_req = 1'b1;
                n_state      = S_UP_WR;
            end
            S_UP_WR: begin
                w_cmd.up_wr = 1'b1;
                w_cmd.last  = r_last;
                if (w_last_ch) begin
                    n_state = S_UP_END;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = S_UP_RD;
                end
            end
            S_UP_END: begin
                if (r_last) begin
                    n_tick = '0;
                    if (i_mode == MODE_STEP || i_mode == MODE_SHADE) begin
                        n_phase = PH_WAIT;
                        n_gi    = r_gi + 1'b1;
                    end else if (i_mode == MODE_BREATHE) begin
                        n_phase = PH_HOLD;
                    end else begin
                        n_phase = PH_IDLE;
                        n_gi    = '0;
                    end
                end
                n_state = S_EMIT;
            end
            S_HOLD: begin
                if (w_tick_inc >= i_hold_n) begin
                    n_tick  = '0;
                    n_phase = PH_DOWN;
                    n_ch    = '0;
                    n_tz    = 1'b1;
                    n_state = S_ST_RD;
                end else begin
                    n_tick  = w_tick_inc;
                    n_state = S_IDLE;
                end
            end
            S_DN_INC: begin
                n_tick  = w_tick_inc;
                n_last  = (w_tick_inc >= i_down_n);
                n_ch    = '0;
                n_state = S_DN_WR;
            end
            S_DN_WR: begin
                w_cmd.down_wr = 1'b1;
                w_cmd.last    = r_last;
                if (w_last_ch) begin
                    n_state = S_DN_END;
                end else begin
                    n_ch    = r_ch + 1'b1;
                end
            end
            S_DN_END: begin
                if (r_last) begin
                    n_tick  = '0;
                    n_phase = PH_WAIT;
                    n_gi    = r_gi + 1'b1;
                end
                n_state = S_EMIT;
            end
            S_ZERO: begin
                w_cmd.zero_all = 1'b1;
                n_phase        = PH_IDLE;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                w_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_gi    <= '0;
            r_ch    <= '0;
            r_last  <= 1'b0;
            r_tz    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_gi    <= n_gi;
            r_ch    <= n_ch;
            r_last  <= n_last;
            r_tz    <= n_tz;
        end
    end

    assign o_cmd = w_cmd;
    assign o_ch  = r_ch;
    assign o_gi  = r_gi;

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_ch} < (CW + 1)'(CHANNELS)))
        else $error("channel counter out of range");

    a_gi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_gi} <= (GW + 1)'(MAX_GROUPS)))
        else $error("group index out of range");

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> (r_state == S_IDLE))
        else $error("emit not followed by idle");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == OP_TICK && r_phase == PH_IDLE)
        |=> (r_state == S_IDLE && !w_cmd.emit))
        else $error("tick while idle started work");

endmodule

>>> rtl/core/lcfs_dp.sv
// lcfs_dp: target table, duty and step registers, step divider, output register
// depends on lcfs_pkg
`timescale 1ns / 1ps

module lcfs_dp
    import lcfs_pkg::*;
#(
    parameter int MAX_GROUPS = 8,
    parameter int CHANNELS   = 5,
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int GW    = $clog2(MAX_GROUPS + 1),
    localparam int DEPTH = MAX_GROUPS * CHANNELS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [CW-1:0]     i_ch,
    input  logic [GW-1:0]     i_gi,
    input  logic [GRP_W-1:0]  i_load_group,
    input  logic [CHN_W-1:0]  i_load_channel,
    input  logic [DUTY_W-1:0] i_load_value,
    input  logic [TICK_W-1:0] i_divisor,
    output t_dp_stat          o_stat,
    output logic              o_valid,
    output logic [DUTY_W-1:0] o_duty [NUM_OUT]
);

    logic [DUTY_W-1:0]        r_mem [DEPTH];
    logic [DEPTH-1:0]         r_vld;
    logic [DUTY_W-1:0]        r_raw;
    logic                     r_rvld;
    logic [DUTY_W-1:0]        r_duty [CHANNELS];
    logic signed [STEP_W-1:0] r_step [CHANNELS];
    logic [TICK_W-1:0]        r_rem;
    logic [DUTY_W-1:0]        r_quo;
    logic [DCNT_W-1:0]        r_dcnt;
    logic                     r_neg;
    logic                     r_nz;
    logic                     r_warm_zero;
    logic                     r_valid;
    logic [DUTY_W-1:0]        r_out [NUM_OUT];

    int                       w_row;
    logic [AW-1:0]            w_raddr;
    logic [AW-1:0]            w_waddr;
    logic                     w_lok;
    logic [DUTY_W-1:0]        w_rdata;
    logic [DUTY_W-1:0]        w_cur;
    logic signed [STEP_W-1:0] w_s;
    logic [DUTY_W-1:0]        w_goal;
    logic signed [STEP_W-1:0] w_diff;
    logic signed [STEP_W-1:0] w_ndiff;
    logic [DUTY_W-1:0]        w_mag;
    logic [TICK_W:0]          w_rem_sh;
    logic [TICK_W:0]          w_rem_sub;
    logic                     w_ge;
    logic signed [STEP_W-1:0] w_qs;
    logic signed [STEP_W-1:0] w_step;
    logic signed [STEP_W:0]   w_sum;
    logic signed [STEP_W:0]   w_tgt;
    logic signed [STEP_W:0]   w_up_t;
    logic signed [STEP_W:0]   w_dn_t;
    logic [DUTY_W-1:0]        w_up;
    logic [DUTY_W-1:0]        w_dn;
    logic [DUTY_W-1:0]        w_pad [NUM_OUT];

    always_comb begin
        w_row   = (int'(i_gi) < MAX_GROUPS) ? int'(i_gi) : 0;
        w_raddr = AW'(w_row * CHANNELS + int'(i_ch));
        w_lok   = (int'(i_load_group) < MAX_GROUPS) && (int'(i_load_channel) < CHANNELS);
        w_waddr = AW'(int'(i_load_group) * CHANNELS + int'(i_load_channel));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_wr && w_lok) begin
            r_mem[w_waddr] <= i_load_value;
        end
        if (i_cmd.rd_req) begin
            r_raw <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_cmd.tbl_wr && w_lok) begin
                r_vld[w_waddr] <= 1'b1;
            end
            if (i_cmd.rd_req) begin
                r_rvld <= r_vld[w_raddr];
            end
        end
    end

    assign w_rdata = r_rvld ? r_raw : '0;
    assign w_cur   = r_duty[i_ch];
    assign w_s     = r_step[i_ch];

    // step divider: |diff| / ramp-up interval, one quotient bit per cycle
    always_comb begin
        w_goal    = i_cmd.toward_zero ? '0 : w_rdata;
        w_diff    = signed'({1'b0, w_goal}) - signed'({1'b0, w_cur});
        w_ndiff   = -w_diff;
        w_mag     = w_diff[STEP_W-1] ? w_ndiff[DUTY_W-1:0] : w_diff[DUTY_W-1:0];
        w_rem_sh  = {r_rem, r_quo[DUTY_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, i_divisor});
        w_rem_sub = w_rem_sh - {1'b0, i_divisor};
        w_qs      = signed'({1'b0, r_quo});
        if (r_quo == '0) begin
            w_step = r_nz ? (r_neg ? -STEP_W'(1) : STEP_W'(1)) : '0;
        end else begin
            w_step = r_neg ? -w_qs : w_qs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dcnt <= DCNT_W'(DIV_STEPS);
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= w_mag;
            r_neg <= w_diff[STEP_W-1];
            r_nz  <= (w_diff != '0);
        end else if (r_dcnt != '0) begin
            r_rem <= w_ge ? w_rem_sub[TICK_W-1:0] : w_rem_sh[TICK_W-1:0];
            r_quo <= {r_quo[DUTY_W-2:0], w_ge};
        end
    end

    // duty update toward the target or toward zero
    always_comb begin
        w_sum = signed'({2'b00, w_cur}) + signed'({w_s[STEP_W-1], w_s});
        w_tgt = signed'({2'b00, w_rdata});
        w_up_t = w_sum;
        if (w_s > 0 && w_sum > w_tgt) begin
            w_up_t = w_tgt;
        end else if (w_s < 0 && w_sum <= w_tgt) begin
            w_up_t = w_tgt;
        end
        if (w_up_t < 0) begin
            w_up_t = w_tgt;
        end
        w_up = i_cmd.last ? w_rdata : w_up_t[DUTY_W-1:0];
        w_dn_t = w_sum;
        if (w_sum < 0 || w_s > 0) begin
            w_dn_t = '0;
        end
        w_dn = i_cmd.last ? '0 : w_dn_t[DUTY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_duty[i] <= '0;
                r_step[i] <= '0;
            end
            r_warm_zero <= 1'b0;
        end else begin
            if (i_cmd.zero_all) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    r_duty[i] <= '0;
                end
            end
            if (i_cmd.step_wr) begin
                r_step[i_ch] <= w_step;
            end
            if (i_cmd.warm_chk) begin
                r_warm_zero <= (w_rdata == '0);
            end
            if (i_cmd.snap_wr) begin
                r_duty[i_ch] <= w_rdata;
                r_step[i_ch] <= '0;
            end
            if (i_cmd.up_wr) begin
                r_duty[i_ch] <= w_up;
            end
            if (i_cmd.down_wr && w_cur != '0) begin
                r_duty[i_ch] <= w_dn;
            end
        end
    end

    for (genvar j = 0; j < NUM_OUT; j++) begin : g_pad
        if (j < CHANNELS) begin : g_used
            assign w_pad[j] = r_duty[j];
        end else begin : g_unused
            assign w_pad[j] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            for (int j = 0; j < NUM_OUT; j++) begin
                r_out[j] <= w_pad[j];
            end
        end
    end

    assign o_stat.div_done  = (r_dcnt == '0);
    assign o_stat.warm_zero = r_warm_zero;
    assign o_valid          = r_valid;
    assign o_duty           = r_out;

endmodule
